// ===== src/expiring_event_time_table_macros.svh =====
// assertion macros for the expiring event time table
`ifndef EXPIRING_EVENT_TIME_TABLE_MACROS_SVH
`define EXPIRING_EVENT_TIME_TABLE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define EETT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EETT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eett_pkg.sv =====
// shared types, constants and digit helpers for the expiring event time table
package eett_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int TIME_W         = 32;
    localparam int SLOT_W         = 8;
    localparam int TONE_W         = 4;

    localparam logic [TONE_W-1:0] NO_TONE = 4'd10;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_SCAN,
        ST_DIG1,
        ST_DIG2
    } eett_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;         // capture the transaction fields, reset the scan
        logic write;        // store into the addressed slot
        logic issue;        // read the next slot during a scan
        logic take_hit;     // clear the matched slot, record its time
        logic digit;        // first step of the seconds digit
        logic finish_miss;  // present a result with no hit
        logic finish_hit;   // present a result with a hit
    } eett_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic found;        // the slot read last cycle has expired
        logic scan_end;     // the slot read last cycle was the final one
    } eett_stat_t;

    // time mod 15: nibbles summed, since 16 is 1 mod 15
    function automatic logic [3:0] mod15_of(input logic [TIME_W-1:0] t);
        logic [6:0] sum;
        logic [4:0] fold;
        sum = 7'd0;
        for (int i = 0; i < TIME_W / 4; i++) begin
            sum = sum + {3'd0, t[4*i +: 4]};
        end
        fold = {2'd0, sum[6:4]} + {1'b0, sum[3:0]};
        if (fold >= 5'd15) begin
            fold = fold - 5'd15;
        end
        return fold[3:0];
    endfunction

    // rebuild time mod 60 from the residues mod 15 and mod 4, then its ones digit
    function automatic logic [TONE_W-1:0] seconds_digit(input logic [3:0] r15,
                                                        input logic [1:0] r4);
        logic [1:0] k;
        logic [5:0] x;
        logic [9:0] prod;
        logic [2:0] q;
        logic [5:0] rem;
        k    = r15[1:0] - r4;
        x    = {2'd0, r15} + 6'({4'd0, k} * 6'd15);
        prod = {4'd0, x} * 10'd13;   // x * 13 / 128 is x / 10 below 60
        q    = prod[9:7];
        rem  = x - 6'({3'd0, q} * 6'd10);
        return rem[TONE_W-1:0];
    endfunction

endpackage

// ===== src/eett_ctrl.sv =====
// controller state machine for the expiring event time table
module eett_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 action,
    input  eett_pkg::eett_stat_t stat,
    output eett_pkg::eett_cmd_t  cmd,
    output logic                 busy
);
    import eett_pkg::*;

    eett_state_t state_reg;
    eett_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (action == ACT_STORE) ? ST_STORE : ST_SCAN;
                end
            end
            ST_STORE:
            begin
                cmd.write       = 1'b1;
                cmd.finish_miss = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_SCAN:
            begin
                priority if (stat.found)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_DIG1;
                end
                else if (stat.scan_end)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DIG1:
            begin
                cmd.digit  = 1'b1;
                state_next = ST_DIG2;
            end
            ST_DIG2:
            begin
                cmd.finish_hit = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== src/eett_dpath.sv =====
// slot memory, scan pipeline, seconds digit and result registers
module eett_dpath #(
    parameter int SLOT_COUNT = eett_pkg::SLOT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  eett_pkg::eett_cmd_t          cmd,
    output eett_pkg::eett_stat_t         stat,
    input  logic [eett_pkg::SLOT_W-1:0]  slot_index,
    input  logic [eett_pkg::TIME_W-1:0]  event_time,
    input  logic [eett_pkg::TIME_W-1:0]  current_time,
    output logic                         done,
    output logic                         hit,
    output logic [eett_pkg::TONE_W-1:0]  tone,
    output logic [eett_pkg::TIME_W-1:0]  last_event
);
    import eett_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    logic [TIME_W-1:0]   mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;

    logic [SLOT_W-1:0]   slot_reg;
    logic [TIME_W-1:0]   event_reg;
    logic [TIME_W-1:0]   now_reg;

    logic [IDX_W-1:0]    idx_reg;
    logic                pend_reg;
    logic [TIME_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_last_reg;

    logic [TIME_W-1:0]   found_reg;
    logic [3:0]          r15_reg;
    logic [1:0]          r4_reg;
    logic [TIME_W-1:0]   last_expired_reg;

    logic                done_reg;
    logic                hit_reg;
    logic [TONE_W-1:0]   tone_reg;

    logic                slot_in_range;
    logic                expired;

    assign slot_in_range = (slot_reg < SLOT_W'(SLOT_COUNT));
    assign expired       = rd_valid_reg && (rd_data_reg != '0) && (rd_data_reg < now_reg);

    assign stat.found    = pend_reg && expired;
    assign stat.scan_end = pend_reg && rd_last_reg;

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot_reg  <= slot_index;
            event_reg <= event_time;
            now_reg   <= current_time;
        end
    end

    // slot memory, data path without reset
    always_ff @(posedge clk)
    begin
        if (cmd.write && slot_in_range)
        begin
            mem[slot_reg[IDX_W-1:0]] <= event_reg;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[idx_reg];
            rd_idx_reg  <= idx_reg;
        end
    end

    // per-slot valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.write && slot_in_range)
            begin
                valid_reg[slot_reg[IDX_W-1:0]] <= 1'b1;
            end
            if (cmd.take_hit)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
        end
    end

    // scan pointer and read tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.issue)
        begin
            idx_reg      <= idx_reg + 1'b1;
            pend_reg     <= 1'b1;
            rd_valid_reg <= valid_reg[idx_reg];
            rd_last_reg  <= (idx_reg == LAST_IDX);
        end
    end

    // seconds digit from the expired time
    always_ff @(posedge clk)
    begin
        if (cmd.take_hit)
        begin
            found_reg <= rd_data_reg;
        end
        if (cmd.digit)
        begin
            r15_reg <= mod15_of(found_reg);
            r4_reg  <= found_reg[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_expired_reg <= '0;
        end
        else if (cmd.take_hit)
        begin
            last_expired_reg <= rd_data_reg;
        end
    end

    // result registers, strobe lasts one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
            tone_reg <= NO_TONE;
        end
        else
        begin
            done_reg <= cmd.finish_miss || cmd.finish_hit;
            if (cmd.finish_hit)
            begin
                hit_reg  <= 1'b1;
                tone_reg <= seconds_digit(r15_reg, r4_reg);
            end
            else if (cmd.finish_miss)
            begin
                hit_reg  <= 1'b0;
                tone_reg <= NO_TONE;
            end
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg && done_reg;
    assign tone       = tone_reg;
    assign last_event = last_expired_reg;

endmodule

// ===== src/expiring_event_time_table.sv =====
// top level of the expiring event time table
// a store transaction passes through the STORE state, which writes the slot, and then the result register
// a check transaction scans one slot per cycle through the slot memory read port:
// a miss answers once the final slot has been read, a hit first clears its slot and builds the seconds digit
// one transaction at a time; busy is high from acceptance until the result strobe,
// the next transaction can be taken at the edge that ends the strobe
// reset clears all slots (valid bits), the last event and the controller at once
`include "expiring_event_time_table_macros.svh"

module expiring_event_time_table #(
    parameter int SLOT_COUNT = eett_pkg::SLOT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // command side: a transaction is taken when start is high and busy is low
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [eett_pkg::SLOT_W-1:0]  slot_index,
    input  logic [eett_pkg::TIME_W-1:0]  event_time,
    input  logic [eett_pkg::TIME_W-1:0]  current_time,
    // result side: one result per transaction, valid for the single cycle done is high
    output logic                         done,
    output logic                         hit,
    output logic [eett_pkg::TONE_W-1:0]  tone,
    output logic [eett_pkg::TIME_W-1:0]  last_event
);
    import eett_pkg::*;

    eett_cmd_t  cmd;
    eett_stat_t stat;

    // controller: sequences store, scan, digit steps and the result strobe
    eett_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // datapath: slot memory with valid bits, scan read pipeline,
    // mod 60 ones digit built from residues mod 15 and mod 4
    eett_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .slot_index   (slot_index),
        .event_time   (event_time),
        .current_time (current_time),
        .done         (done),
        .hit          (hit),
        .tone         (tone),
        .last_event   (last_event)
    );

    // a miss always carries the no-tone code
    `EETT_ASSERT_NOW(a_miss_tone, done && !hit, tone == NO_TONE, "miss result without no-tone code")
    // a hit carries a real digit and a nonzero expired time
    `EETT_ASSERT_NOW(a_hit_digit, hit, done && (tone < NO_TONE) && (last_event != '0), "bad hit result")
    // an accepted transaction holds the block busy next cycle
    `EETT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    // the result strobe comes as the block goes idle
    `EETT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")

endmodule

// ===== test/expiring_event_time_table_checker.sv =====
`timescale 1ns / 100ps
// checker for the expiring event time table: alarm table prediction and result compare
module expiring_event_time_table_checker
    import eett_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              action,
    input  logic [SLOT_W-1:0] slot_index,
    input  logic [TIME_W-1:0] event_time,
    input  logic [TIME_W-1:0] current_time,
    input  logic              done,
    input  logic              hit,
    input  logic [TONE_W-1:0] tone,
    input  logic [TIME_W-1:0] last_event,
    output int                pending,
    output int                failures
);

    typedef struct packed {
        logic              hit;
        logic [TONE_W-1:0] tone;
        logic [TIME_W-1:0] last_event;
    } alarm_answer_t;

    // predicted table contents, zero marks an empty slot
    logic [TIME_W-1:0] alarm_times [SLOT_COUNT];
    logic [TIME_W-1:0] last_expired_time;
    alarm_answer_t     answers_due [$];
    int                mismatch_count = 0;

    // apply one transaction to the predicted table and return its answer
    function automatic alarm_answer_t expire_or_store(input logic              act,
                                                      input logic [SLOT_W-1:0] idx,
                                                      input logic [TIME_W-1:0] ev,
                                                      input logic [TIME_W-1:0] now);
        alarm_answer_t ans;
        ans.hit  = 1'b0;
        ans.tone = NO_TONE;
        if (act == ACT_STORE)
        begin
            if (idx < SLOT_COUNT)
            begin
                alarm_times[idx] = ev;
            end
        end
        else
        begin
            // lowest slot first, strictly earlier only
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (!ans.hit && alarm_times[i] != '0 && alarm_times[i] < now)
                begin
                    ans.hit           = 1'b1;
                    ans.tone          = TONE_W'((alarm_times[i] % 60) % 10);
                    last_expired_time = alarm_times[i];
                    alarm_times[i]    = '0;
                end
            end
        end
        ans.last_event = last_expired_time;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alarm_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                alarm_times[i] = '0;
            end
            last_expired_time = '0;
            answers_due.delete();
            pending  <= 0;
            failures <= mismatch_count;
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t ns: result with none expected, hit %0d tone %0d last_event %0d",
                             $time, hit, tone, last_event);
                    mismatch_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (hit !== want.hit)
                    begin
                        $display("%0t ns: hit expected %0d, got %0d", $time, want.hit, hit);
                        mismatch_count++;
                    end
                    if (tone !== want.tone)
                    begin
                        $display("%0t ns: tone expected %0d, got %0d", $time, want.tone, tone);
                        mismatch_count++;
                    end
                    if (last_event !== want.last_event)
                    begin
                        $display("%0t ns: last_event expected %0d, got %0d",
                                 $time, want.last_event, last_event);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                answers_due.push_back(expire_or_store(action, slot_index, event_time,
                                                      current_time));
            end
            pending  <= answers_due.size();
            failures <= mismatch_count;
        end
    end

endmodule

// ===== test/expiring_event_time_table_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the expiring event time table: stimulus, reset and verdict
module expiring_event_time_table_tb;

    import eett_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS = 1600;
    // limit for the hard stop below, sized with room for the long idle phase
    localparam int CYCLE_LIMIT  = 400000;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              action       = ACT_STORE;
    logic [SLOT_W-1:0] slot_index   = '0;
    logic [TIME_W-1:0] event_time   = '0;
    logic [TIME_W-1:0] current_time = '0;
    logic              busy;
    logic              done;
    logic              hit;
    logic [TONE_W-1:0] tone;
    logic [TIME_W-1:0] last_event;

    int                pending;
    int                failures;
    int unsigned       cycle_count = 0;

    expiring_event_time_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .slot_index   (slot_index),
        .event_time   (event_time),
        .current_time (current_time),
        .done         (done),
        .hit          (hit),
        .tone         (tone),
        .last_event   (last_event)
    );

    // watches both sides, predicts every transaction and counts mismatches
    expiring_event_time_table_checker #(
        .SLOT_COUNT (SLOTS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .slot_index   (slot_index),
        .event_time   (event_time),
        .current_time (current_time),
        .done         (done),
        .hit          (hit),
        .tone         (tone),
        .last_event   (last_event),
        .pending      (pending),
        .failures     (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // hold one transaction on the command side until busy is low at an edge
    task automatic present_request(input logic              act,
                                   input logic [SLOT_W-1:0] idx,
                                   input logic [TIME_W-1:0] ev,
                                   input logic [TIME_W-1:0] now);
        start        <= 1'b1;
        action       <= act;
        slot_index   <= idx;
        event_time   <= ev;
        current_time <= now;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // sender gap: start low, junk on the fields, pct chance per cycle to stay idle
    task automatic sender_pause(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start        <= 1'b0;
            action       <= 1'($urandom());
            slot_index   <= SLOT_W'($urandom());
            event_time   <= $urandom();
            current_time <= $urandom();
            @(posedge clk);
        end
    endtask

    // stop sending and wait until every outstanding result has come back
    task automatic wait_for_answers;
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    initial
    begin
        logic [TIME_W-1:0] clock_base;
        logic [SLOT_W-1:0] idx;
        logic [TIME_W-1:0] ev;
        int                idle_pct;
        int                roll;

        // reset held low from the start, then released once
        repeat (10)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        // empty table: nothing to expire, no event yet
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        // equal time has not expired
        present_request(ACT_STORE, 8'd0, 32'hFFFF_FFFF, 32'd0);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        present_request(ACT_STORE, 8'd15, 32'd1, 32'd0);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'd1);
        // top slot expires at the smallest nonzero time
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'd2);
        // stores past the table end are dropped
        present_request(ACT_STORE, 8'(SLOTS), 32'd5, 32'd0);
        present_request(ACT_STORE, 8'd255, 32'hAAAA_5555, 32'hFFFF_FFFF);
        present_request(ACT_CHECK, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // unsigned compare across the top bit
        present_request(ACT_STORE, 8'd3, 32'd59, 32'd0);
        present_request(ACT_STORE, 8'd7, 32'h7FFF_FFFF, 32'd0);
        present_request(ACT_STORE, 8'd2, 32'h8000_0000, 32'd0);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'h8000_0000);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'h8000_0000);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'h8000_0001);
        // writing zero empties a slot
        present_request(ACT_STORE, 8'd4, 32'h1234_5678, 32'd0);
        present_request(ACT_STORE, 8'd4, 32'd0, 32'd0);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'd0);
        // lowest numbered slot wins over an older time in a higher slot
        present_request(ACT_STORE, 8'd9, 32'd10, 32'd0);
        present_request(ACT_STORE, 8'd1, 32'd20, 32'd0);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'd1000);
        present_request(ACT_CHECK, 8'd0, 32'd0, 32'd1000);
        present_request(ACT_STORE, 8'd0, 32'd0, 32'd0);
        wait_for_answers();

        // random part: sender idles 29%, then 87%, then not at all
        clock_base = $urandom();
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 29 : (phase == 1) ? 87 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                sender_pause(idle_pct);
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    // noise: any field values at all
                    present_request(1'($urandom()), SLOT_W'($urandom()), $urandom(),
                                    $urandom());
                end
                else if (roll < 55)
                begin
                    // alarm a little ahead of the running clock, sometimes out of range or empty
                    if ($urandom_range(0, 9) == 0)
                        idx = SLOT_W'($urandom_range(SLOTS, 255));
                    else
                        idx = SLOT_W'($urandom_range(0, SLOTS - 1));
                    if ($urandom_range(0, 19) == 0)
                        ev = '0;
                    else
                        ev = clock_base + $urandom_range(0, 120);
                    present_request(ACT_STORE, idx, ev, $urandom());
                end
                else
                begin
                    // check a little past the running clock, then let it advance
                    present_request(ACT_CHECK, SLOT_W'($urandom()), $urandom(),
                                    clock_base + $urandom_range(0, 160));
                    clock_base = clock_base + $urandom_range(0, 40);
                end
                // occasional jump of the clock, now and then right before the wrap
                if ($urandom_range(0, 199) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        clock_base = $urandom();
                    else
                        clock_base = 32'hFFFF_FF80;
                end
            end
            // sender holds off until the block has answered everything
            wait_for_answers();
        end

        // let any stray result show up before the verdict
        repeat (SLOTS + 4)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/eett_pkg.sv
src/eett_ctrl.sv
src/eett_dpath.sv
src/expiring_event_time_table.sv
test/expiring_event_time_table_checker.sv
test/expiring_event_time_table_tb.sv
